FILE: sv/arc_pkg.sv
// Shared types, constants and codes for the ARP resolver cache.
`default_nettype none

package arc_pkg;

  // Storage sizes
  localparam int CACHE_ENTRIES = 16;
  localparam int PEND_DEPTH    = 16;
  localparam int WAIT_DEPTH    = 16;

  localparam int CI_W   = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CC_W   = $clog2(CACHE_ENTRIES + 1);
  localparam int PI_W   = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
  localparam int PC_W   = $clog2(PEND_DEPTH + 1);
  localparam int WI_W   = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int WC_W   = $clog2(WAIT_DEPTH + 1);

  // Cache entry layout: {ip, mac, expiry}
  localparam int CACHE_W = 32 + 48 + 64;
  // Wait entry layout: {tag, ip}
  localparam int WAIT_W  = 16 + 32;

  // Register indexes
  localparam logic [1:0] REG_OWN_MAC  = 2'd0;
  localparam logic [1:0] REG_OWN_IP   = 2'd1;
  localparam logic [1:0] REG_LIFETIME = 2'd2;
  localparam logic [1:0] REG_RETRY    = 2'd3;

  localparam logic [31:0] LIFETIME_RESET = 32'(30 * 1000);
  localparam logic [31:0] RETRY_RESET    = 32'd5000;

  // Request types
  localparam logic [1:0] REQ_SEND  = 2'd0;
  localparam logic [1:0] REQ_FRAME = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_IPV4    = 3'd0;
  localparam logic [2:0] KIND_REQUEST = 3'd1;
  localparam logic [2:0] KIND_REPLY   = 3'd2;
  localparam logic [2:0] KIND_DELIVER = 3'd3;
  localparam logic [2:0] KIND_DROP    = 3'd4;

  localparam logic [15:0] ETH_IPV4   = 16'h0800;
  localparam logic [15:0] ETH_ARP    = 16'h0806;
  localparam logic [15:0] OP_REQUEST = 16'd1;
  localparam logic [47:0] MAC_BCAST  = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [2:0]  kind;
    logic [47:0] dst_mac;
    logic [15:0] tag;
    logic [31:0] ip;
    logic [47:0] mac;
  } result_t;

  typedef struct packed {
    logic push;
    logic flush;
  } buf_ctrl_t;

  typedef struct packed {
    logic push_ok;
    logic flush_ok;
    logic hold_valid;
  } buf_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SEND_SCAN, ST_SEND_OUT, ST_SEND_PUSH, ST_RETRY_RD, ST_RETRY_CHK,
    ST_IPV4_OUT, ST_LEARN_SCAN, ST_LEARN_WR, ST_REPLY, ST_PEND_RD, ST_PEND_KEY,
    ST_PEND_SCAN, ST_WAIT_RD, ST_WAIT_KEY, ST_WAIT_SCAN, ST_WAIT_EMIT, ST_FLUSH
  } state_t;

endpackage

`default_nettype wire

FILE: sv/arc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module arc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/arc_result_buf.sv
// Result staging: one held result plus the output register, to mark the last one.
`default_nettype none

module arc_result_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire arc_pkg::buf_ctrl_t ctrl,
  input  wire arc_pkg::result_t  push_data,
  output arc_pkg::buf_stat_t     stat,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             out_kind,
  output logic [47:0]            dst_mac,
  output logic [15:0]            out_tag,
  output logic [31:0]            arp_ip_out,
  output logic [47:0]            arp_mac_out,
  output logic                   last
);

  arc_pkg::result_t hold;
  arc_pkg::result_t out_r;
  logic             hold_v;
  logic             out_free;

  assign out_free        = !out_valid || out_ready;
  assign stat.push_ok    = !hold_v || out_free;
  assign stat.flush_ok   = hold_v && out_free;
  assign stat.hold_valid = hold_v;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      hold_v    <= 1'b0;
    end else begin
      if ((ctrl.push && hold_v) || (!ctrl.push && ctrl.flush)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      if (ctrl.push) begin
        hold_v <= 1'b1;
      end else if (ctrl.flush) begin
        hold_v <= 1'b0;
      end
    end
  end

  // Payload: a new result pushes the held one out as not-last
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      hold <= push_data;
      if (hold_v) begin
        out_r <= hold;
        last  <= 1'b0;
      end
    end else if (ctrl.flush) begin
      out_r <= hold;
      last  <= 1'b1;
    end
  end

  assign out_kind    = out_r.kind;
  assign dst_mac     = out_r.dst_mac;
  assign out_tag     = out_r.tag;
  assign arp_ip_out  = out_r.ip;
  assign arp_mac_out = out_r.mac;

endmodule

`default_nettype wire

FILE: sv/arp_resolver_cache.sv
// ARP resolver cache: sequencer around cache, pending and wait memories.
//
//  Channel | Direction | Handshake            | Payload
//  in      | input     | in_valid / in_ready  | req_type .. elapsed_ms
//  out     | output    | out_valid / out_ready| out_kind .. arp_mac_out, last
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// One transaction at a time. A cache search reads one entry a cycle from the
// cache RAM; a send takes one search and then a result or a queue write with a
// retry check, a tick a retry check, an ARP frame one learn search (with a good
// payload) plus one search per queue head examined. Reset is synchronous; valid
// bits, counters and queue pointers clear at once, the memories need no clearing.
// A stalled output holds the sequencer where it emits; a new input is taken once the last result is staged.
`default_nettype none

module arp_resolver_cache (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [47:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  req_type,
  input  wire logic [31:0] hop_ip,
  input  wire logic [15:0] frame_tag,
  input  wire logic [47:0] frame_dst_mac,
  input  wire logic [15:0] frame_ethertype,
  input  wire logic        payload_ok,
  input  wire logic [15:0] arp_opcode,
  input  wire logic [47:0] arp_sender_mac,
  input  wire logic [31:0] arp_sender_ip,
  input  wire logic [31:0] arp_target_ip,
  input  wire logic [31:0] elapsed_ms,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic [47:0]      dst_mac,
  output logic [15:0]      out_tag,
  output logic [31:0]      arp_ip_out,
  output logic [47:0]      arp_mac_out,
  output logic             last
);

  localparam int N = arc_pkg::CACHE_ENTRIES;

  arc_pkg::state_t state, state_next;

  // Configuration
  logic [47:0] own_mac;
  logic [31:0] own_ip, lifetime_ms, retry_ms;

  // Time and retry
  logic [63:0] now_ms, retry_stamp;
  logic        retry_active;

  // Queues
  logic [arc_pkg::PI_W-1:0] phead, ptail;
  logic [arc_pkg::PC_W-1:0] pcount;
  logic [arc_pkg::WI_W-1:0] whead, wtail;
  logic [arc_pkg::WC_W-1:0] wcount;

  // Captured request
  logic [31:0] r_hop, r_sip, r_tip;
  logic [15:0] r_tag, r_opcode;
  logic [47:0] r_smac;

  // Cache
  logic [N-1:0]                  cache_valid;
  logic [arc_pkg::CACHE_W-1:0]   cache_rdata, cache_wdata;
  logic [arc_pkg::CI_W-1:0]      cache_waddr;
  logic [31:0]                   c_ip;
  logic [47:0]                   c_mac;
  logic [63:0]                   c_exp;

  // Scan pipeline
  logic [arc_pkg::CC_W-1:0] scan_idx;
  logic [arc_pkg::CI_W-1:0] chk_idx;
  logic                     chk_v, scanning, scan_done;
  logic [31:0]              scan_key;
  logic                     lk_hit, cur_hit, hit_now;
  logic [47:0]              lk_mac;
  logic [15:0]              cur_tag;

  // Learn slot search
  logic                     same_f, exp_f, min_f, any_free;
  logic [arc_pkg::CI_W-1:0] same_slot, exp_slot, min_slot, free_slot;
  logic [63:0]              min_exp;

  // Queue memories
  logic [31:0]                pend_rdata;
  logic [arc_pkg::WAIT_W-1:0] wait_rdata;

  // Strobes
  logic accept, pend_pop, wait_pop, push_wr, retry_fire, learn_wr, retry_due;
  logic dst_ok, cfull;
  logic [63:0] age;

  arc_pkg::buf_ctrl_t bctrl;
  arc_pkg::buf_stat_t bstat;
  arc_pkg::result_t   pdata;

  assign in_ready = (state == arc_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign dst_ok   = (frame_dst_mac == arc_pkg::MAC_BCAST) || (frame_dst_mac == own_mac);
  assign cfull    = (pcount == arc_pkg::PC_W'(arc_pkg::PEND_DEPTH)) ||
                    (wcount == arc_pkg::WC_W'(arc_pkg::WAIT_DEPTH));
  assign age       = now_ms - retry_stamp;
  assign retry_due = (pcount != '0) && (!retry_active || (age > {32'd0, retry_ms}));

  assign c_ip  = cache_rdata[143:112];
  assign c_mac = cache_rdata[111:64];
  assign c_exp = cache_rdata[63:0];

  assign scanning  = (state == arc_pkg::ST_SEND_SCAN) || (state == arc_pkg::ST_LEARN_SCAN) ||
                     (state == arc_pkg::ST_PEND_SCAN) || (state == arc_pkg::ST_WAIT_SCAN);
  assign scan_done = chk_v && (chk_idx == arc_pkg::CI_W'(N - 1));
  assign cur_hit   = chk_v && cache_valid[chk_idx] && (c_ip == scan_key) && (now_ms <= c_exp);
  assign hit_now   = lk_hit || cur_hit;

  // Lowest invalid cache slot
  always_comb begin
    free_slot = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!cache_valid[i]) free_slot = arc_pkg::CI_W'(i);
    end
  end
  assign any_free = ~&cache_valid;

  assign cache_waddr = same_f ? same_slot : (any_free ? free_slot : (exp_f ? exp_slot : min_slot));
  assign cache_wdata = {r_sip, r_smac, now_ms + {32'd0, lifetime_ms}};

  // Memories
  arc_ram #(.WIDTH(arc_pkg::CACHE_W), .DEPTH(N)) u_cache_ram (
    .clk(clk), .we(learn_wr), .waddr(cache_waddr), .wdata(cache_wdata),
    .raddr(scan_idx[arc_pkg::CI_W-1:0]), .rdata(cache_rdata)
  );

  arc_ram #(.WIDTH(32), .DEPTH(arc_pkg::PEND_DEPTH)) u_pend_ram (
    .clk(clk), .we(push_wr), .waddr(ptail), .wdata(r_hop),
    .raddr(phead), .rdata(pend_rdata)
  );

  arc_ram #(.WIDTH(arc_pkg::WAIT_W), .DEPTH(arc_pkg::WAIT_DEPTH)) u_wait_ram (
    .clk(clk), .we(push_wr), .waddr(wtail), .wdata({r_tag, r_hop}),
    .raddr(whead), .rdata(wait_rdata)
  );

  arc_result_buf u_buf (
    .clk(clk), .rst(rst), .ctrl(bctrl), .push_data(pdata), .stat(bstat),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .dst_mac(dst_mac), .out_tag(out_tag), .arp_ip_out(arp_ip_out),
    .arp_mac_out(arp_mac_out), .last(last)
  );

  // Next state and outputs
  always_comb begin
    state_next = state;
    bctrl      = '0;
    pdata      = '0;
    pend_pop   = 1'b0;
    wait_pop   = 1'b0;
    push_wr    = 1'b0;
    retry_fire = 1'b0;
    learn_wr   = 1'b0;
    case (state)
      arc_pkg::ST_IDLE: begin
        if (accept) begin
          case (req_type)
            arc_pkg::REQ_SEND: state_next = arc_pkg::ST_SEND_SCAN;
            arc_pkg::REQ_TICK: state_next = arc_pkg::ST_RETRY_RD;
            arc_pkg::REQ_FRAME: begin
              if (!dst_ok) state_next = arc_pkg::ST_FLUSH;
              else if (frame_ethertype == arc_pkg::ETH_IPV4)
                state_next = payload_ok ? arc_pkg::ST_IPV4_OUT : arc_pkg::ST_FLUSH;
              else if (frame_ethertype == arc_pkg::ETH_ARP)
                state_next = payload_ok ? arc_pkg::ST_LEARN_SCAN : arc_pkg::ST_PEND_RD;
              else state_next = arc_pkg::ST_FLUSH;
            end
            default: state_next = arc_pkg::ST_FLUSH;
          endcase
        end
      end
      arc_pkg::ST_SEND_SCAN: begin
        if (scan_done)
          state_next = (hit_now || cfull) ? arc_pkg::ST_SEND_OUT : arc_pkg::ST_SEND_PUSH;
      end
      arc_pkg::ST_SEND_OUT: begin
        pdata.kind    = lk_hit ? arc_pkg::KIND_IPV4 : arc_pkg::KIND_DROP;
        pdata.dst_mac = lk_hit ? lk_mac : 48'd0;
        pdata.tag     = r_tag;
        if (bstat.push_ok) begin
          bctrl.push = 1'b1;
          state_next = arc_pkg::ST_FLUSH;
        end
      end
      arc_pkg::ST_SEND_PUSH: begin
        push_wr    = 1'b1;
        state_next = arc_pkg::ST_RETRY_RD;
      end
      arc_pkg::ST_RETRY_RD: state_next = arc_pkg::ST_RETRY_CHK;
      arc_pkg::ST_RETRY_CHK: begin
        pdata.kind    = arc_pkg::KIND_REQUEST;
        pdata.dst_mac = arc_pkg::MAC_BCAST;
        pdata.ip      = pend_rdata;
        if (!retry_due) state_next = arc_pkg::ST_FLUSH;
        else if (bstat.push_ok) begin
          bctrl.push = 1'b1;
          retry_fire = 1'b1;
          state_next = arc_pkg::ST_FLUSH;
        end
      end
      arc_pkg::ST_IPV4_OUT: begin
        pdata.kind = arc_pkg::KIND_DELIVER;
        pdata.tag  = r_tag;
        if (bstat.push_ok) begin
          bctrl.push = 1'b1;
          state_next = arc_pkg::ST_FLUSH;
        end
      end
      arc_pkg::ST_LEARN_SCAN: begin
        if (scan_done) state_next = arc_pkg::ST_LEARN_WR;
      end
      arc_pkg::ST_LEARN_WR: begin
        learn_wr   = 1'b1;
        state_next = ((r_opcode == arc_pkg::OP_REQUEST) && (r_tip == own_ip)) ?
                     arc_pkg::ST_REPLY : arc_pkg::ST_PEND_RD;
      end
      arc_pkg::ST_REPLY: begin
        pdata.kind    = arc_pkg::KIND_REPLY;
        pdata.dst_mac = r_smac;
        pdata.ip      = r_sip;
        pdata.mac     = r_smac;
        if (bstat.push_ok) begin
          bctrl.push = 1'b1;
          state_next = arc_pkg::ST_PEND_RD;
        end
      end
      arc_pkg::ST_PEND_RD: begin
        state_next = (pcount == '0) ? arc_pkg::ST_WAIT_RD : arc_pkg::ST_PEND_KEY;
      end
      arc_pkg::ST_PEND_KEY: state_next = arc_pkg::ST_PEND_SCAN;
      arc_pkg::ST_PEND_SCAN: begin
        if (scan_done) begin
          if (hit_now) begin
            pend_pop   = 1'b1;
            state_next = arc_pkg::ST_PEND_RD;
          end else begin
            state_next = arc_pkg::ST_WAIT_RD;
          end
        end
      end
      arc_pkg::ST_WAIT_RD: begin
        state_next = (wcount == '0) ? arc_pkg::ST_FLUSH : arc_pkg::ST_WAIT_KEY;
      end
      arc_pkg::ST_WAIT_KEY: state_next = arc_pkg::ST_WAIT_SCAN;
      arc_pkg::ST_WAIT_SCAN: begin
        if (scan_done) state_next = hit_now ? arc_pkg::ST_WAIT_EMIT : arc_pkg::ST_FLUSH;
      end
      arc_pkg::ST_WAIT_EMIT: begin
        pdata.kind    = arc_pkg::KIND_IPV4;
        pdata.dst_mac = lk_mac;
        pdata.tag     = cur_tag;
        if (bstat.push_ok) begin
          bctrl.push = 1'b1;
          wait_pop   = 1'b1;
          state_next = arc_pkg::ST_WAIT_RD;
        end
      end
      arc_pkg::ST_FLUSH: begin
        if (!bstat.hold_valid) state_next = arc_pkg::ST_IDLE;
        else if (bstat.flush_ok) begin
          bctrl.flush = 1'b1;
          state_next  = arc_pkg::ST_IDLE;
        end
      end
      default: state_next = arc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= arc_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Configuration, time, retry, queue and valid state
  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac      <= '0;
      own_ip       <= '0;
      lifetime_ms  <= arc_pkg::LIFETIME_RESET;
      retry_ms     <= arc_pkg::RETRY_RESET;
      now_ms       <= '0;
      retry_stamp  <= '0;
      retry_active <= 1'b0;
      phead        <= '0;
      ptail        <= '0;
      pcount       <= '0;
      whead        <= '0;
      wtail        <= '0;
      wcount       <= '0;
      cache_valid  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          arc_pkg::REG_OWN_MAC:  own_mac     <= cfg_data;
          arc_pkg::REG_OWN_IP:   own_ip      <= cfg_data[31:0];
          arc_pkg::REG_LIFETIME: lifetime_ms <= cfg_data[31:0];
          arc_pkg::REG_RETRY:    retry_ms    <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (accept && (req_type == arc_pkg::REQ_TICK)) now_ms <= now_ms + {32'd0, elapsed_ms};
      if (retry_fire) begin
        retry_stamp  <= now_ms;
        retry_active <= 1'b1;
      end
      if (push_wr) begin
        ptail  <= (ptail == arc_pkg::PI_W'(arc_pkg::PEND_DEPTH - 1)) ? '0 : ptail + 1'b1;
        pcount <= pcount + 1'b1;
        wtail  <= (wtail == arc_pkg::WI_W'(arc_pkg::WAIT_DEPTH - 1)) ? '0 : wtail + 1'b1;
        wcount <= wcount + 1'b1;
      end
      if (pend_pop) begin
        phead        <= (phead == arc_pkg::PI_W'(arc_pkg::PEND_DEPTH - 1)) ? '0 : phead + 1'b1;
        pcount       <= pcount - 1'b1;
        retry_active <= 1'b0;
      end
      if (wait_pop) begin
        whead  <= (whead == arc_pkg::WI_W'(arc_pkg::WAIT_DEPTH - 1)) ? '0 : whead + 1'b1;
        wcount <= wcount - 1'b1;
      end
      if (learn_wr) cache_valid[cache_waddr] <= 1'b1;
    end
  end

  // Scan pipeline: address issue, then the check in the following cycle
  always_ff @(posedge clk) begin
    if (rst || !scanning) begin
      scan_idx <= '0;
      chk_v    <= 1'b0;
    end else begin
      if (scan_idx != arc_pkg::CC_W'(N)) scan_idx <= scan_idx + 1'b1;
      chk_v <= (scan_idx != arc_pkg::CC_W'(N));
    end
  end

  // Captured request, search keys and search results
  always_ff @(posedge clk) begin
    chk_idx <= scan_idx[arc_pkg::CI_W-1:0];
    if (accept) begin
      r_hop    <= hop_ip;
      r_tag    <= frame_tag;
      r_opcode <= arp_opcode;
      r_smac   <= arp_sender_mac;
      r_sip    <= arp_sender_ip;
      r_tip    <= arp_target_ip;
      scan_key <= hop_ip;
    end
    if (state == arc_pkg::ST_PEND_KEY) scan_key <= pend_rdata;
    if (state == arc_pkg::ST_WAIT_KEY) begin
      scan_key <= wait_rdata[31:0];
      cur_tag  <= wait_rdata[47:32];
    end
    // lookup
    if (state == arc_pkg::ST_IDLE || state == arc_pkg::ST_PEND_KEY ||
        state == arc_pkg::ST_WAIT_KEY) begin
      lk_hit <= 1'b0;
    end else if (scanning && cur_hit && !lk_hit) begin
      lk_hit <= 1'b1;
      lk_mac <= c_mac;
    end
    // replacement search
    if (state != arc_pkg::ST_LEARN_SCAN) begin
      if (state != arc_pkg::ST_LEARN_WR) begin
        same_f <= 1'b0;
        exp_f  <= 1'b0;
        min_f  <= 1'b0;
      end
    end else if (chk_v && cache_valid[chk_idx]) begin
      if (!same_f && (c_ip == r_sip)) begin
        same_f    <= 1'b1;
        same_slot <= chk_idx;
      end
      if (!exp_f && (now_ms > c_exp)) begin
        exp_f    <= 1'b1;
        exp_slot <= chk_idx;
      end
      if (!min_f || (c_exp < min_exp)) begin
        min_f    <= 1'b1;
        min_slot <= chk_idx;
        min_exp  <= c_exp;
      end
    end
  end

  // Checks
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == arc_pkg::ST_IDLE |-> !bstat.hold_valid) else $error("held result at idle");
  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pcount <= arc_pkg::PC_W'(arc_pkg::PEND_DEPTH)) else $error("pending overflow");
  a_wait_bound: assert property (@(posedge clk) disable iff (rst)
    wcount <= arc_pkg::WC_W'(arc_pkg::WAIT_DEPTH)) else $error("wait overflow");
  a_push_ok: assert property (@(posedge clk) disable iff (rst)
    bctrl.push |-> bstat.push_ok) else $error("push into full buffer");
  a_push_full: assert property (@(posedge clk) disable iff (rst)
    push_wr |-> !cfull) else $error("queue write when full");

endmodule

`default_nettype wire

FILE: test/arp_resolver_cache_tb.sv
// Self-checking testbench for the ARP resolver cache: random stimulus and a behavioral predictor.
`timescale 1ns / 100ps
`default_nettype none

module arp_resolver_cache_tb;

  typedef struct {
    logic [1:0]  rtype;
    logic [31:0] hop;
    logic [15:0] tag;
    logic [47:0] fdst;
    logic [15:0] etype;
    logic        ok;
    logic [15:0] opcode;
    logic [47:0] smac;
    logic [31:0] sip;
    logic [31:0] tip;
    logic [31:0] elapsed;
  } request_t;

  typedef struct {
    logic [2:0]  kind;
    logic [47:0] dst;
    logic [15:0] tag;
    logic [31:0] ip;
    logic [47:0] mac;
    logic        fin;
  } frame_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] req_type = '0;
  logic [31:0] hop_ip = '0;
  logic [15:0] frame_tag = '0;
  logic [47:0] frame_dst_mac = '0;
  logic [15:0] frame_ethertype = '0;
  logic payload_ok = 1'b0;
  logic [15:0] arp_opcode = '0;
  logic [47:0] arp_sender_mac = '0;
  logic [31:0] arp_sender_ip = '0;
  logic [31:0] arp_target_ip = '0;
  logic [31:0] elapsed_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_kind;
  logic [47:0] dst_mac;
  logic [15:0] out_tag;
  logic [31:0] arp_ip_out;
  logic [47:0] arp_mac_out;
  logic last;

  arp_resolver_cache dut (.*);

  always #10 clk = ~clk;

  // Predictor state
  logic [47:0] p_own_mac;
  logic [31:0] p_own_ip, p_life, p_retry;
  logic [63:0] p_now;
  logic [31:0] c_ip [arc_pkg::CACHE_ENTRIES];
  logic [47:0] c_mac [arc_pkg::CACHE_ENTRIES];
  logic [63:0] c_exp [arc_pkg::CACHE_ENTRIES];
  bit          c_vld [arc_pkg::CACHE_ENTRIES];
  logic [31:0] pend_q[$];
  logic [15:0] wtag_q[$];
  logic [31:0] wip_q[$];
  bit          rty_active;
  logic [63:0] rty_stamp;

  request_t   pending_reqs[$];
  frame_out_t expected_frames[$];
  int  errors = 0;
  bit  stim_done = 0;
  bit  quiet = 0;     // no idling while set
  bit  in_taken = 0;  // input transaction at the last rising edge

  function automatic void post(logic [2:0] k, logic [47:0] d, logic [15:0] t,
                               logic [31:0] ip, logic [47:0] m);
    frame_out_t f;
    f.kind = k; f.dst = d; f.tag = t; f.ip = ip; f.mac = m; f.fin = 1'b0;
    expected_frames.push_back(f);
  endfunction

  function automatic bit resolve(logic [31:0] ip, output logic [47:0] m);
    m = '0;
    for (int i = 0; i < arc_pkg::CACHE_ENTRIES; i++)
      if (c_vld[i] && c_ip[i] == ip && p_now <= c_exp[i]) begin
        m = c_mac[i];
        return 1;
      end
    return 0;
  endfunction

  function automatic void learn_mapping(logic [31:0] ip, logic [47:0] m);
    int slot;
    slot = -1;
    for (int i = 0; i < arc_pkg::CACHE_ENTRIES && slot < 0; i++)
      if (c_vld[i] && c_ip[i] == ip) slot = i;
    for (int i = 0; i < arc_pkg::CACHE_ENTRIES && slot < 0; i++)
      if (!c_vld[i]) slot = i;
    for (int i = 0; i < arc_pkg::CACHE_ENTRIES && slot < 0; i++)
      if (p_now > c_exp[i]) slot = i;
    if (slot < 0) begin
      slot = 0;
      for (int i = 1; i < arc_pkg::CACHE_ENTRIES; i++)
        if (c_exp[i] < c_exp[slot]) slot = i;
    end
    c_vld[slot] = 1; c_ip[slot] = ip; c_mac[slot] = m;
    c_exp[slot] = p_now + 64'(p_life);
  endfunction

  function automatic void arp_resend();
    if (pend_q.size() == 0) return;
    if (!rty_active || (p_now - rty_stamp) > 64'(p_retry)) begin
      rty_stamp = p_now;
      rty_active = 1;
      post(arc_pkg::KIND_REQUEST, arc_pkg::MAC_BCAST, '0, pend_q[0], '0);
    end
  endfunction

  // Compute all frames one request causes
  function automatic void resolve_request(request_t r);
    logic [47:0] m;
    int n0;
    n0 = expected_frames.size();
    case (r.rtype)
      arc_pkg::REQ_SEND: begin
        if (resolve(r.hop, m)) post(arc_pkg::KIND_IPV4, m, r.tag, '0, '0);
        else if (pend_q.size() >= arc_pkg::PEND_DEPTH || wtag_q.size() >= arc_pkg::WAIT_DEPTH)
          post(arc_pkg::KIND_DROP, '0, r.tag, '0, '0);
        else begin
          pend_q.push_back(r.hop);
          arp_resend();
          wtag_q.push_back(r.tag);
          wip_q.push_back(r.hop);
        end
      end
      arc_pkg::REQ_FRAME: begin
        if (r.fdst == arc_pkg::MAC_BCAST || r.fdst == p_own_mac) begin
          if (r.etype == arc_pkg::ETH_IPV4) begin
            if (r.ok) post(arc_pkg::KIND_DELIVER, '0, r.tag, '0, '0);
          end else if (r.etype == arc_pkg::ETH_ARP) begin
            if (r.ok) begin
              learn_mapping(r.sip, r.smac);
              if (r.opcode == arc_pkg::OP_REQUEST && r.tip == p_own_ip)
                post(arc_pkg::KIND_REPLY, r.smac, '0, r.sip, r.smac);
            end
            while (pend_q.size() > 0 && resolve(pend_q[0], m)) begin
              void'(pend_q.pop_front());
              rty_active = 0;
            end
            while (wip_q.size() > 0 && resolve(wip_q[0], m)) begin
              post(arc_pkg::KIND_IPV4, m, wtag_q[0], '0, '0);
              void'(wtag_q.pop_front());
              void'(wip_q.pop_front());
            end
          end
        end
      end
      arc_pkg::REQ_TICK: begin
        p_now = p_now + 64'(r.elapsed);
        arp_resend();
      end
      default: ;
    endcase
    if (expected_frames.size() > n0)
      expected_frames[expected_frames.size() - 1].fin = 1'b1;
  endfunction

  // Driver: valid held until accepted, changes on falling edge
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        resolve_request(pending_reqs.pop_front());
      end
      if (in_taken || !in_valid) begin
        if (pending_reqs.size() > 0 && (quiet || $urandom_range(99) >= 34)) begin
          in_valid <= 1'b1;
          req_type <= pending_reqs[0].rtype;
          hop_ip <= pending_reqs[0].hop;
          frame_tag <= pending_reqs[0].tag;
          frame_dst_mac <= pending_reqs[0].fdst;
          frame_ethertype <= pending_reqs[0].etype;
          payload_ok <= pending_reqs[0].ok;
          arp_opcode <= pending_reqs[0].opcode;
          arp_sender_mac <= pending_reqs[0].smac;
          arp_sender_ip <= pending_reqs[0].sip;
          arp_target_ip <= pending_reqs[0].tip;
          elapsed_ms <= pending_reqs[0].elapsed;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= quiet || ($urandom_range(99) >= 34);
    end
  end

  // Handshake seen at the rising edge; the driver pops at the next falling edge
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && in_ready;
  end

  // Monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    frame_out_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected result kind=%0d dst=%h tag=%h", $time, out_kind,
                 dst_mac, out_tag);
        errors++;
      end else begin
        e = expected_frames.pop_front();
        if (out_kind !== e.kind || dst_mac !== e.dst || out_tag !== e.tag ||
            arp_ip_out !== e.ip || arp_mac_out !== e.mac || last !== e.fin) begin
          $display("%0t: mismatch expected kind=%0d dst=%h tag=%h ip=%h mac=%h last=%b",
                   $time, e.kind, e.dst, e.tag, e.ip, e.mac, e.fin);
          $display("%0t:          actual   kind=%0d dst=%h tag=%h ip=%h mac=%h last=%b",
                   $time, out_kind, dst_mac, out_tag, arp_ip_out, arp_mac_out, last);
          errors++;
        end
      end
    end
  end

  function automatic request_t blank();
    request_t r;
    r.rtype = arc_pkg::REQ_TICK; r.hop = '0; r.tag = '0; r.fdst = '0; r.etype = '0;
    r.ok = 1'b0; r.opcode = '0; r.smac = '0; r.sip = '0; r.tip = '0; r.elapsed = '0;
    return r;
  endfunction

  function automatic request_t send_req(logic [31:0] ip, logic [15:0] t);
    request_t r;
    r = blank(); r.rtype = arc_pkg::REQ_SEND; r.hop = ip; r.tag = t;
    return r;
  endfunction

  function automatic request_t tick_req(logic [31:0] ms);
    request_t r;
    r = blank(); r.elapsed = ms;
    return r;
  endfunction

  function automatic request_t arp_req(logic [47:0] d, logic [15:0] op, logic [47:0] sm,
                                       logic [31:0] si, logic [31:0] ti, logic ok);
    request_t r;
    r = blank(); r.rtype = arc_pkg::REQ_FRAME; r.fdst = d; r.etype = arc_pkg::ETH_ARP;
    r.opcode = op; r.smac = sm; r.sip = si; r.tip = ti; r.ok = ok;
    return r;
  endfunction

  function automatic request_t noise_req();
    request_t r;
    r.rtype = 2'($urandom); r.hop = $urandom; r.tag = 16'($urandom);
    r.fdst = {16'($urandom), 32'($urandom)}; r.etype = 16'($urandom);
    r.ok = 1'($urandom); r.opcode = 16'($urandom);
    r.smac = {16'($urandom), 32'($urandom)}; r.sip = $urandom; r.tip = $urandom;
    r.elapsed = $urandom;
    return r;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [47:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      arc_pkg::REG_OWN_MAC:  p_own_mac = val;
      arc_pkg::REG_OWN_IP:   p_own_ip = val[31:0];
      arc_pkg::REG_LIFETIME: p_life = val[31:0];
      default:               p_retry = val[31:0];
    endcase
  endtask

  // Wait until the block drained everything, then a settle time
  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_frames.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    request_t r;
    int sel, ip_base;
    logic [47:0] bm;
    logic [31:0] ipp [8];
    p_own_mac = '0; p_own_ip = '0; p_life = arc_pkg::LIFETIME_RESET;
    p_retry = arc_pkg::RETRY_RESET;
    p_now = '0; rty_active = 0; rty_stamp = '0;
    for (int i = 0; i < arc_pkg::CACHE_ENTRIES; i++) begin
      c_vld[i] = 0; c_ip[i] = '0; c_mac[i] = '0; c_exp[i] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed, reset configuration then own addresses
    write_reg(arc_pkg::REG_OWN_MAC, 48'h02_00_00_00_00_01);
    write_reg(arc_pkg::REG_OWN_IP, 32'h0A00_0001);
    pending_reqs.push_back(send_req(32'hC0A8_0001, 16'h0001));
    pending_reqs.push_back(send_req(32'hC0A8_0001, 16'h0002));
    pending_reqs.push_back(tick_req(32'd5000));
    pending_reqs.push_back(tick_req(32'd1));
    pending_reqs.push_back(arp_req(arc_pkg::MAC_BCAST, 16'd2, 48'hAA_BB_CC_DD_EE_FF,
                                   32'hC0A8_0001, 32'h0A00_0001, 1'b1));
    pending_reqs.push_back(send_req(32'hC0A8_0001, 16'hFFFF));
    pending_reqs.push_back(arp_req(48'h02_00_00_00_00_01, arc_pkg::OP_REQUEST,
                                   48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h0A00_0001, 1'b1));
    pending_reqs.push_back(arp_req(arc_pkg::MAC_BCAST, arc_pkg::OP_REQUEST, 48'h0, 32'h0,
                                   32'h0A00_0001, 1'b0));
    pending_reqs.push_back(arp_req(48'h12_34_56_78_9A_BC, arc_pkg::OP_REQUEST, 48'h1, 32'h1,
                                   32'h0A00_0001, 1'b1));
    r = blank(); r.rtype = arc_pkg::REQ_FRAME; r.fdst = arc_pkg::MAC_BCAST;
    r.etype = arc_pkg::ETH_IPV4; r.ok = 1'b1; r.tag = 16'hBEEF; pending_reqs.push_back(r);
    r.ok = 1'b0; pending_reqs.push_back(r);
    r.ok = 1'b1; r.etype = 16'hFFFF; pending_reqs.push_back(r);
    r = blank(); r.rtype = 2'd3; r.elapsed = 32'hFFFF_FFFF; pending_reqs.push_back(r);
    // fill queues to overflow
    for (int i = 0; i < 17; i++) pending_reqs.push_back(send_req(32'h0B00_0000 + i, 16'(i)));
    pending_reqs.push_back(tick_req(32'hFFFF_FFFF));
    drain();

    // Extreme configuration; lifetime and retry set to 1, their smallest nonzero values
    write_reg(arc_pkg::REG_OWN_MAC, 48'hFFFF_FFFF_FFFE);
    write_reg(arc_pkg::REG_OWN_IP, 32'hFFFF_FFFF);
    write_reg(arc_pkg::REG_LIFETIME, 48'd1);
    write_reg(arc_pkg::REG_RETRY, 48'd1);
    quiet = 1;
    for (int i = 0; i < 17; i++)
      pending_reqs.push_back(arp_req(arc_pkg::MAC_BCAST, 16'd2, 48'(i) + 48'h0100,
                                     32'h0B00_0000 + i, 32'h0, 1'b1));
    pending_reqs.push_back(tick_req(32'd1));
    pending_reqs.push_back(tick_req(32'd2));
    drain();
    quiet = 0;

    // Random phases, mostly well-formed traffic on a small address pool
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          write_reg(arc_pkg::REG_LIFETIME, 48'd40); write_reg(arc_pkg::REG_RETRY, 48'd3);
        end
        1: begin
          write_reg(arc_pkg::REG_LIFETIME, 48'hFFFF_FFFF);
          write_reg(arc_pkg::REG_RETRY, 48'hFFFF_FFFF);
        end
        default: begin
          write_reg(arc_pkg::REG_LIFETIME, 48'd10); write_reg(arc_pkg::REG_RETRY, 48'd1);
        end
      endcase
      write_reg(arc_pkg::REG_OWN_IP, 48'($urandom));
      write_reg(arc_pkg::REG_OWN_MAC, {16'($urandom), 32'($urandom)});
      ip_base = $urandom;
      for (int i = 0; i < 8; i++) ipp[i] = ip_base + i;
      for (int i = 0; i < 27; i++) begin
        sel = $urandom_range(99);
        bm = ($urandom_range(3) == 0) ? p_own_mac : arc_pkg::MAC_BCAST;
        if (sel < 35) r = send_req(ipp[$urandom_range(7)], 16'($urandom));
        else if (sel < 60)
          r = arp_req(bm, 16'($urandom_range(2, 1)), {16'($urandom), 32'($urandom)},
                      ipp[$urandom_range(7)],
                      ($urandom_range(1) ? p_own_ip : $urandom), $urandom_range(9) != 0);
        else if (sel < 80) r = tick_req($urandom_range(15));
        else if (sel < 85) r = tick_req($urandom);
        else begin
          r = noise_req();
          if ($urandom_range(1)) r.fdst = bm;
        end
        pending_reqs.push_back(r);
      end
      drain();
    end
    stim_done = 1;
  end

  // Final verdict
  initial begin
    wait (stim_done);
    if (errors == 0 && expected_frames.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
sv/arc_pkg.sv
sv/arc_ram.sv
sv/arc_result_buf.sv
sv/arp_resolver_cache.sv
test/arp_resolver_cache_tb.sv
